>>> rtl/wildcard_substring_finder_assert.svh
// ----------------------------------------------------------------------------
// wildcard substring finder assertion macros
// concurrent checks used by the top module
// ----------------------------------------------------------------------------
`ifndef WILDCARD_SUBSTRING_FINDER_ASSERT_SVH
`define WILDCARD_SUBSTRING_FINDER_ASSERT_SVH

// same-cycle implication, off during reset
`define WSF_ASSERT_IMPL(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("wsf check failed");

// next-cycle implication, off during reset
`define WSF_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("wsf check failed");

`endif

>>> rtl/wsf_pkg.sv
// ----------------------------------------------------------------------------
// wsf_pkg
// shared types, codes and constants of the wildcard substring finder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsf_pkg;

  // default sizes
  localparam int DEF_MAX_PATTERN = 16;
  localparam int DEF_LINE_BITS   = 32;
  localparam int DEF_COLUMN_BITS = 16;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 64;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_FIRST  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LAST   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LENGTH = 2'd2;
  localparam int PATTERN_LENGTH_BITS = 5;

  // special bytes
  localparam logic [7:0] WILDCARD        = 8'h3F;
  localparam logic [7:0] CARRIAGE_RETURN = 8'h0D;

  // result kinds
  localparam logic KIND_MATCH = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  // input actions
  typedef enum logic [1:0] {
    ACT_TEXT     = 2'd0,
    ACT_END_LINE = 2'd1,
    ACT_END_FILE = 2'd2,
    ACT_IGNORED  = 2'd3
  } action_t;

  // queued item
  typedef struct packed {
    action_t    action;
    logic [7:0] data_byte;
  } item_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

  // result payload, first field in the highest bits
  typedef struct packed {
    logic [31:0] total_matches;
    logic [63:0] matched_last_eight;
    logic [63:0] matched_first_eight;
    logic [15:0] column;
    logic [31:0] line_number;
  } result_t;

  localparam int OUT_DATA_BITS = $bits(result_t);

endpackage

>>> rtl/wsf_front.sv
// ----------------------------------------------------------------------------
// wsf_front
// accepts input transactions, decodes the action and feeds the queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsf_front (
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // data_byte
  input  logic [1:0]          s_tuser,   // action
  input  wsf_pkg::q_status_t  q_status,
  output logic                push,
  output wsf_pkg::item_t      push_item
);

  wsf_pkg::action_t action;

  // decode and push; ignored codes are consumed without a queue entry
  always_comb begin
    action              = wsf_pkg::action_t'(s_tuser);
    s_tready            = !q_status.full;
    push_item.action    = action;
    push_item.data_byte = s_tdata;
    push                = s_tvalid && s_tready && (action != wsf_pkg::ACT_IGNORED);
  end

endmodule

>>> rtl/wsf_queue.sv
// ----------------------------------------------------------------------------
// wsf_queue
// short fifo of decoded items between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsf_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  wsf_pkg::item_t     push_item,
  input  logic               pop,
  output wsf_pkg::item_t     pop_item,
  output wsf_pkg::q_status_t status
);

  localparam int DEPTH = wsf_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  wsf_pkg::item_t   entries [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == PTR_LAST) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == PTR_LAST) ? '0 : head + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // head item and status
  always_comb begin
    pop_item     = entries[head];
    status.valid = (count != '0);
    status.full  = (count == CNT_W'(DEPTH));
  end

endmodule

>>> rtl/wsf_back.sv
// ----------------------------------------------------------------------------
// wsf_back
// pattern registers, byte window, match compare, counters and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsf_back #(
  parameter int MAX_PATTERN = wsf_pkg::DEF_MAX_PATTERN,
  parameter int LINE_BITS   = wsf_pkg::DEF_LINE_BITS,
  parameter int COLUMN_BITS = wsf_pkg::DEF_COLUMN_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wsf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [wsf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  wsf_pkg::q_status_t                  q_status,
  input  wsf_pkg::item_t                      pop_item,
  output logic                                pop,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [wsf_pkg::OUT_DATA_BITS-1:0]   m_tdata,  // line_number, column,
                                                        // matched_first_eight,
                                                        // matched_last_eight,
                                                        // total_matches
  output logic                                m_tuser   // kind
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam logic [COLUMN_BITS-1:0] COLUMN_MAX = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;
  localparam logic [LINE_BITS-1:0]   LINE_FIRST = LINE_BITS'(1);

  // pattern registers
  logic [63:0]                                pattern_first;
  logic [63:0]                                pattern_last;
  logic [wsf_pkg::PATTERN_LENGTH_BITS-1:0]    pattern_length;

  // scan state
  logic [7:0]             window [MAX_PATTERN];
  logic [7:0]             window_next [MAX_PATTERN];
  logic [COLUMN_BITS-1:0] bytes_in_line;
  logic [COLUMN_BITS-1:0] bytes_in_line_next;
  logic [LEN_W-1:0]       blocked;
  logic [LEN_W-1:0]       blocked_next;
  logic [LINE_BITS-1:0]   line_count;
  logic [LINE_BITS-1:0]   line_count_next;
  logic [31:0]            match_total;
  logic [31:0]            match_total_next;

  // result register
  logic                   out_valid;
  logic                   out_kind;
  wsf_pkg::result_t       out_result;

  // step signals
  logic                   advance;
  logic [LEN_W-1:0]       len;
  logic [7:0]             shifted [MAX_PATTERN];
  logic [7:0]             aligned [MAX_PATTERN];
  logic [7:0]             pbyte [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] ok;
  logic                   hit;
  logic [63:0]            matched_lo;
  logic [63:0]            matched_hi;
  logic [COLUMN_BITS-1:0] bil_inc;
  logic [COLUMN_BITS-1:0] len_ext;
  logic [COLUMN_BITS-1:0] col;
  logic [31:0]            total_inc;
  logic                   emit;
  logic                   emit_kind;
  wsf_pkg::result_t       emit_result;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_first  <= '0;
      pattern_last   <= '0;
      pattern_length <= wsf_pkg::PATTERN_LENGTH_BITS'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wsf_pkg::CFG_PATTERN_FIRST:  pattern_first  <= cfg_data;
        wsf_pkg::CFG_PATTERN_LAST:   pattern_last   <= cfg_data;
        wsf_pkg::CFG_PATTERN_LENGTH:
          pattern_length <= cfg_data[wsf_pkg::PATTERN_LENGTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // effective pattern length, zero reads as one, clamped to the window
  always_comb begin
    if (pattern_length == '0) begin
      len = LEN_W'(1);
    end else if (int'(pattern_length) > MAX_PATTERN) begin
      len = LEN_W'(MAX_PATTERN);
    end else begin
      len = LEN_W'(pattern_length);
    end
  end

  // window with the incoming byte at the newest position
  always_comb begin
    shifted[0] = pop_item.data_byte;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      shifted[i] = window[i-1];
    end
  end

  // text byte that lines up with each pattern byte, zero beyond the length
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      aligned[k] = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
        if ((k < int'(len)) && (int'(len) - 1 - k == j)) begin
          aligned[k] = shifted[j];
        end
      end
    end
  end

  // per-byte compare
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cmp
    if (k < 8) begin : g_first
      assign pbyte[k] = pattern_first[8*k +: 8];
    end else if (k < 16) begin : g_last
      assign pbyte[k] = pattern_last[8*(k-8) +: 8];
    end else begin : g_none
      assign pbyte[k] = '0;
    end
    assign ok[k] = (k >= int'(len)) ||
                   ((pbyte[k] == wsf_pkg::WILDCARD) ?
                    (aligned[k] != wsf_pkg::CARRIAGE_RETURN) :
                    (pbyte[k] == aligned[k]));
  end

  assign hit = &ok;

  // matched bytes, only the first sixteen are reported
  always_comb begin
    matched_lo = '0;
    matched_hi = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (k < 8) begin
        matched_lo[8*(k % 8) +: 8] = aligned[k];
      end else if (k < 16) begin
        matched_hi[8*(k % 8) +: 8] = aligned[k];
      end
    end
  end

  // counters and column
  always_comb begin
    bil_inc   = (bytes_in_line == COLUMN_MAX) ? bytes_in_line : bytes_in_line + 1'b1;
    len_ext   = COLUMN_BITS'(len);
    col       = (bil_inc == COLUMN_MAX) ? COLUMN_MAX : bil_inc - len_ext + 1'b1;
    total_inc = (match_total == '1) ? match_total : match_total + 1'b1;
  end

  // back takes an item when the result slot is free or draining
  assign advance = q_status.valid && (!out_valid || m_tready);
  assign pop     = advance;

  // one item step
  always_comb begin
    window_next        = window;
    bytes_in_line_next = bytes_in_line;
    blocked_next       = blocked;
    line_count_next    = line_count;
    match_total_next   = match_total;
    emit               = 1'b0;
    emit_kind          = wsf_pkg::KIND_MATCH;
    emit_result        = '0;
    if (advance) begin
      unique case (pop_item.action)
        wsf_pkg::ACT_TEXT: begin
          window_next        = shifted;
          bytes_in_line_next = bil_inc;
          if (blocked != '0) begin
            blocked_next = blocked - 1'b1;
          end else if ((bil_inc >= len_ext) && hit) begin
            emit                            = 1'b1;
            match_total_next                = total_inc;
            blocked_next                    = len - 1'b1;
            emit_result.line_number         = 32'(line_count);
            emit_result.column              = 16'(col);
            emit_result.matched_first_eight = matched_lo;
            emit_result.matched_last_eight  = matched_hi;
            emit_result.total_matches       = total_inc;
          end
        end
        wsf_pkg::ACT_END_LINE: begin
          line_count_next    = (line_count == LINE_MAX) ? line_count
                                                        : line_count + 1'b1;
          bytes_in_line_next = '0;
          blocked_next       = '0;
        end
        wsf_pkg::ACT_END_FILE: begin
          emit                      = 1'b1;
          emit_kind                 = wsf_pkg::KIND_TOTAL;
          emit_result.total_matches = match_total;
          line_count_next           = LINE_FIRST;
          match_total_next          = '0;
          bytes_in_line_next        = '0;
          blocked_next              = '0;
        end
        default: ;
      endcase
    end
  end

  // window bytes outside the current line are never compared
  always_ff @(posedge clk) begin
    window <= window_next;
  end

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_line <= '0;
      blocked       <= '0;
      line_count    <= LINE_FIRST;
      match_total   <= '0;
    end else begin
      bytes_in_line <= bytes_in_line_next;
      blocked       <= blocked_next;
      line_count    <= line_count_next;
      match_total   <= match_total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind   <= emit_kind;
      out_result <= emit_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_result;
  assign m_tuser  = out_kind;

endmodule

>>> rtl/wildcard_substring_finder.sv
// ----------------------------------------------------------------------------
// wildcard_substring_finder: one byte per cycle unless m_tready stalls
// an accepted byte is queued, then compared; results go to a result register
// reset: synchronous rst empties the queue, sets line one, count zero, length one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "wildcard_substring_finder_assert.svh"

module wildcard_substring_finder #(
  parameter int MAX_PATTERN = wsf_pkg::DEF_MAX_PATTERN,
  parameter int LINE_BITS   = wsf_pkg::DEF_LINE_BITS,
  parameter int COLUMN_BITS = wsf_pkg::DEF_COLUMN_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,   // data_byte
  input  logic [1:0]                          s_tuser,   // action
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [wsf_pkg::OUT_DATA_BITS-1:0]   m_tdata,   // line_number, column,
                                                         // matched_first_eight,
                                                         // matched_last_eight,
                                                         // total_matches
  output logic                                m_tuser,   // kind
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wsf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [wsf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  wsf_pkg::q_status_t q_status;
  wsf_pkg::item_t     push_item;
  wsf_pkg::item_t     pop_item;
  wsf_pkg::result_t   out_view;
  logic               push;
  logic               pop;

  // decode side
  wsf_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue
  wsf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  // search side
  wsf_back #(
    .MAX_PATTERN (MAX_PATTERN),
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .pop_item  (pop_item),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  assign out_view = m_tdata;

  // checks
  `WSF_ASSERT_IMPL(a_pop_needs_item, clk, rst, pop, q_status.valid)
  `WSF_ASSERT_NEXT(a_push_fills, clk, rst, push && !pop, q_status.valid)
  `WSF_ASSERT_IMPL(a_total_no_position, clk, rst, m_tvalid && (m_tuser == wsf_pkg::KIND_TOTAL), (out_view.line_number == '0) && (out_view.column == '0))
  `WSF_ASSERT_IMPL(a_match_counted, clk, rst, m_tvalid && (m_tuser == wsf_pkg::KIND_MATCH), out_view.total_matches != '0)

endmodule
